// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define FSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define FSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fsr_pkg.sv =====
package fsr_pkg;

  localparam int MEM_AW      = 8;
  localparam int TICK_GAP    = 14336;
  localparam int LINE_CYCLES = 112;
  localparam logic [15:0] SCROLL_STEP_RST = 16'd50;
  localparam logic [13:0] RECIP7 = 14'd9362;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_FEND  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_TICK_CHK,
    S_TICK_START,
    S_TICK_ELAP,
    S_DIV,
    S_QUO,
    S_FE,
    S_FE_BIT,
    S_FILL_CHK,
    S_FILL_WR,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [15:0]       wr_data;
  } mem_req_t;

endpackage

// ===== sv/fsr_frame_mem.sv =====
`include "assert_macros.svh"

module fsr_frame_mem
  import fsr_pkg::*;
#(
  parameter int DEPTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [15:0]      q_r;
  logic             qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      q_r  <= mem[req.rd_addr[AW-1:0]];
      qv_r <= vld_r[req.rd_addr[AW-1:0]];
    end
  end

  // an entry never written since the last clear reads as zero
  assign rdata = qv_r ? q_r : '0;

  `FSR_ASSERT(a_rw_apart, (req.rd_en && req.wr_en) |-> (req.rd_addr != req.wr_addr), "read and write hit one entry")
  `FSR_ASSERT(a_clr_alone, req.clr |-> (!req.wr_en && !req.rd_en), "clear overlaps an access")
  `FSR_ASSERT(a_wr_range, req.wr_en |-> (32'(req.wr_addr) < DEPTH), "write beyond memory")

endmodule

// ===== sv/flash_scanline_recorder_top.sv =====
// Flash scanline recorder. Keeps one flash bit per scanline in three rotating
// frame buffers held in a single 16-bit-wide memory (LINES/16+1 words per
// buffer, one read and one write port, registered read data). A read request
// fetches its word and registers its bit into the output in S_RD_OUT and
// holds the input stalled there, longer while an earlier result waits; a
// clear adds no stall. A flash tick stalls the input through S_TICK,
// S_TICK_CHK and S_TICK_START (only on the first tick of a frame),
// S_TICK_ELAP, S_DIV and S_QUO (while the frame is filling) and the fill;
// a frame end through S_FE, S_FE_BIT (when a fill is part done) and the fill.
// The fill is a read-modify-write walk over the memory, one word a cycle.
// Configuration writes are taken at any cycle.
`include "assert_macros.svh"

module flash_scanline_recorder_top
  import fsr_pkg::*;
#(
  parameter int LINES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // scroll_step
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,    // time_req[47:0], line[55:48]
  input  logic [1:0]  in_tuser,    // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // line_flash[0], zero fill
);

  localparam int WORDS    = LINES / 16 + 1;
  localparam int DEPTH    = 3 * WORDS;
  localparam int FW       = $clog2(LINES + 1);
  localparam int XW       = $clog2(7 * LINES + 1);
  localparam int PW       = XW + 14;
  localparam int FULL_CYC = LINE_CYCLES * LINES;

  state_t        state_r, state_nxt;
  logic [15:0]   foff_r, foff_nxt;
  logic [1:0]    rot_r, rot_nxt;
  logic [FW-1:0] fi_r, fi_nxt;
  logic          lvl_r, lvl_nxt;
  logic          open_r, open_nxt;
  logic [48:0]   fstart_r, fstart_nxt;
  logic [47:0]   last_r, last_nxt;
  logic [47:0]   scroll_r, scroll_nxt;
  logic          fe_r, fe_nxt;
  logic          ov_r, ov_nxt;

  logic [47:0]   t_r, t_nxt;
  logic [7:0]    line_r, line_nxt;
  logic [48:0]   diff_r, diff_nxt;
  logic [47:0]   ssum_r, ssum_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [FW-1:0] lim_r, lim_nxt;
  logic          fv_r, fv_nxt;
  logic          obit_r, obit_nxt;

  mem_req_t      mreq;
  logic [15:0]   rdata;

  logic [1:0]    wbuf;
  logic [31:0]   wbase, sbase;
  logic [48:0]   ssum;
  logic [49:0]   elapsed;
  logic [XW-3:0] q0;
  logic [XW:0]   q7, rem;
  logic [FW-1:0] last_idx, fi_m1, fi_next_word;
  logic          same_word;
  logic [15:0]   mask;
  logic          fin;

  fsr_frame_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rdata (rdata)
  );

  always_comb begin
    unique case (rot_r)
      2'd0:    wbuf = 2'd2;
      2'd1:    wbuf = 2'd0;
      default: wbuf = 2'd1;
    endcase
  end

  assign wbase        = 32'(wbuf) * WORDS;
  assign sbase        = 32'(rot_r) * WORDS;
  assign ssum         = {1'b0, scroll_r} + 49'(foff_r);
  assign elapsed      = {2'b00, t_r} - {1'b0, fstart_r};
  assign q0           = prod_r[PW-1:16];
  assign q7           = {q0, 3'b000} - (XW + 1)'(q0);
  assign rem          = {1'b0, x_r} - q7;
  assign last_idx     = lim_r - 1'b1;
  assign fi_m1        = fi_r - 1'b1;
  assign same_word    = (last_idx[FW-1:4] == fi_r[FW-1:4]);
  assign fi_next_word = {fi_r[FW-1:4] + 1'b1, 4'b0000};
  assign mask         = (16'hFFFF << fi_r[3:0])
                      & (same_word ? (16'hFFFF >> (4'd15 - last_idx[3:0])) : 16'hFFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    foff_nxt   = cfg_we ? cfg_wdata : foff_r;
    rot_nxt    = rot_r;
    fi_nxt     = fi_r;
    lvl_nxt    = lvl_r;
    open_nxt   = open_r;
    fstart_nxt = fstart_r;
    last_nxt   = last_r;
    scroll_nxt = scroll_r;
    fe_nxt     = fe_r;
    ov_nxt     = ov_r && !out_tready;
    t_nxt      = t_r;
    line_nxt   = line_r;
    diff_nxt   = diff_r;
    ssum_nxt   = ssum_r;
    x_nxt      = x_r;
    prod_nxt   = prod_r;
    lim_nxt    = lim_r;
    fv_nxt     = fv_r;
    obit_nxt   = obit_r;
    mreq       = '0;
    in_tready  = 1'b0;
    fin        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          t_nxt    = in_tdata[47:0];
          line_nxt = in_tdata[55:48];
          unique case (req_t'(in_tuser))
            REQ_TICK: begin
              fe_nxt    = 1'b0;
              state_nxt = S_TICK;
            end
            REQ_CLEAR: begin
              mreq.clr = 1'b1;
              rot_nxt  = '0;
              fi_nxt   = '0;
              lvl_nxt  = 1'b0;
              open_nxt = 1'b0;
            end
            REQ_FEND: begin
              fe_nxt    = 1'b1;
              state_nxt = S_FE;
            end
            REQ_READ: begin
              mreq.rd_en   = (32'(in_tdata[55:52]) < WORDS);
              mreq.rd_addr = MEM_AW'(sbase + 32'(in_tdata[55:52]));
              state_nxt    = S_RD_OUT;
            end
          endcase
        end
      end

      S_RD_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          obit_nxt  = (32'(line_r[7:4]) < WORDS) ? rdata[line_r[3:0]] : 1'b0;
          state_nxt = S_IDLE;
        end
      end

      S_TICK: begin
        lvl_nxt = ~lvl_r;
        if (!open_r) begin
          ssum_nxt  = ssum[48] ? '1 : ssum[47:0];
          diff_nxt  = {1'b0, t_r} - {1'b0, last_r};
          state_nxt = S_TICK_CHK;
        end else begin
          state_nxt = S_TICK_ELAP;
        end
      end

      S_TICK_CHK: begin
        if ($signed(diff_r) < $signed(49'(TICK_GAP))) begin
          lvl_nxt = 1'b0;
        end
        scroll_nxt = ($signed({2'b00, ssum_r}) > $signed({diff_r, 1'b0})) ? '0 : ssum_r;
        state_nxt  = S_TICK_START;
      end

      S_TICK_START: begin
        fstart_nxt = {1'b0, t_r} + {1'b0, scroll_r};
        open_nxt   = 1'b1;
        state_nxt  = S_TICK_ELAP;
      end

      S_TICK_ELAP: begin
        last_nxt = t_r;
        fv_nxt   = lvl_r;
        if (elapsed[49]) begin
          state_nxt = S_IDLE;
        end else if (elapsed >= 50'(FULL_CYC)) begin
          lim_nxt   = FW'(LINES);
          state_nxt = S_FILL_CHK;
        end else begin
          x_nxt     = elapsed[XW+3:4];
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        prod_nxt  = PW'(x_r) * PW'(RECIP7);
        state_nxt = S_QUO;
      end

      S_QUO: begin
        lim_nxt   = FW'(32'(q0) + 32'(rem >= (XW + 1)'(7)) + 32'd1);
        state_nxt = S_FILL_CHK;
      end

      S_FE: begin
        lim_nxt = FW'(LINES);
        if ((fi_r < FW'(LINES)) && (fi_r != '0)) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = MEM_AW'(wbase + 32'(fi_m1[FW-1:4]));
          state_nxt    = S_FE_BIT;
        end else begin
          fv_nxt    = lvl_r;
          state_nxt = S_FILL_CHK;
        end
      end

      S_FE_BIT: begin
        fv_nxt    = rdata[fi_m1[3:0]];
        state_nxt = S_FILL_CHK;
      end

      S_FILL_CHK: begin
        if (fi_r < lim_r) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = MEM_AW'(wbase + 32'(fi_r[FW-1:4]));
          state_nxt    = S_FILL_WR;
        end else begin
          fin = 1'b1;
        end
      end

      S_FILL_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = MEM_AW'(wbase + 32'(fi_r[FW-1:4]));
        mreq.wr_data = (rdata & ~mask) | (fv_r ? mask : 16'h0000);
        if (same_word) begin
          fi_nxt = lim_r;
          fin    = 1'b1;
        end else begin
          fi_nxt       = fi_next_word;
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = MEM_AW'(wbase + 32'(fi_next_word[FW-1:4]));
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
      if (fe_r) begin
        rot_nxt  = (rot_r == 2'd2) ? 2'd0 : rot_r + 2'd1;
        open_nxt = 1'b0;
        fi_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      foff_r   <= SCROLL_STEP_RST;
      rot_r    <= '0;
      fi_r     <= '0;
      lvl_r    <= 1'b0;
      open_r   <= 1'b0;
      fstart_r <= '0;
      last_r   <= '0;
      scroll_r <= '0;
      fe_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      foff_r   <= foff_nxt;
      rot_r    <= rot_nxt;
      fi_r     <= fi_nxt;
      lvl_r    <= lvl_nxt;
      open_r   <= open_nxt;
      fstart_r <= fstart_nxt;
      last_r   <= last_nxt;
      scroll_r <= scroll_nxt;
      fe_r     <= fe_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    line_r <= line_nxt;
    diff_r <= diff_nxt;
    ssum_r <= ssum_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    lim_r  <= lim_nxt;
    fv_r   <= fv_nxt;
    obit_r <= obit_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'b0000000, obit_r};

  `FSR_ASSERT(a_fi_bound, fi_r <= FW'(LINES), "fill index past last line")
  `FSR_ASSERT(a_rot_range, rot_r != 2'd3, "rotation out of range")
  `FSR_ASSERT(a_fill_live, (state_r == S_FILL_WR) |-> (fi_r < lim_r), "fill word with nothing to fill")
  `FSR_ASSERT(a_out_src, $rose(out_tvalid) |-> $past(state_r == S_RD_OUT), "result without read")

endmodule

// ===== tb/tb_flash_scanline_recorder_top.sv =====
`timescale 1ns / 100ps

module tb_flash_scanline_recorder_top
  import fsr_pkg::*;
();

  localparam int     N_LINES = 255;
  localparam int     N_WORDS = N_LINES / 16 + 1;
  localparam longint FULL48  = 64'h0000_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;    // time_req[47:0], line[55:48]
  logic [1:0]  in_tuser = '0;    // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // line_flash[0], zero fill

  flash_scanline_recorder_top #(.LINES(N_LINES)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // line buffer state held by the predictor
  logic [15:0] line_mem [3*N_WORDS];
  int          buf_rot;
  int          fill_idx;
  bit          flash_lvl;
  longint      frm_start;
  longint      prev_tick;
  longint      scroll_ofs;
  bit          frm_open;
  longint      ofs_reg;

  bit          line_flash_q [$];
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned burst_left = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  typedef struct {
    req_t        op;
    logic [47:0] t;
    logic [7:0]  ln;
    int          known;
  } dir_row_t;

  dir_row_t dir_rows [23] = '{
    '{REQ_READ,  48'd0,              8'd0,   0},
    '{REQ_READ,  48'hFFFF_FFFF_FFFF, 8'd255, 0},
    '{REQ_TICK,  48'd0,              8'd0,  -1},
    '{REQ_TICK,  48'd20000,          8'd0,  -1},
    '{REQ_TICK,  48'd40000,          8'd0,  -1},
    '{REQ_FEND,  48'd0,              8'd0,  -1},
    '{REQ_TICK,  48'd60000,          8'd0,  -1},
    '{REQ_FEND,  48'd0,              8'd0,  -1},
    '{REQ_READ,  48'd0,              8'd0,  -1},
    '{REQ_READ,  48'd0,              8'd100, -1},
    '{REQ_READ,  48'd0,              8'd254, -1},
    '{REQ_READ,  48'd0,              8'd255, -1},
    '{REQ_FEND,  48'd0,              8'd0,  -1},
    '{REQ_READ,  48'd0,              8'd5,  -1},
    '{REQ_CLEAR, 48'hFFFF_FFFF_FFFF, 8'd255, -1},
    '{REQ_READ,  48'd0,              8'd5,   0},
    '{REQ_TICK,  48'd100,            8'd0,  -1},
    '{REQ_TICK,  48'hFFFF_FFFF_FFFF, 8'd0,  -1},
    '{REQ_TICK,  48'hFFFF_FFFF_FFFF, 8'd0,  -1},
    '{REQ_FEND,  48'd0,              8'd0,  -1},
    '{REQ_FEND,  48'd0,              8'd0,  -1},
    '{REQ_READ,  48'd0,              8'd0,  -1},
    '{REQ_READ,  48'd0,              8'd200, -1}
  };

  task automatic flag_err(string what);
    err_cnt++;
    if (err_cnt <= 50) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic logic [47:0] rnd48();
    return {16'($urandom()), $urandom()};
  endfunction

  function automatic void put_line(int base, int idx, bit v);
    if ((idx >> 4) < N_WORDS) line_mem[base + (idx >> 4)][idx & 15] = v;
  endfunction

  function automatic bit get_line(int base, int idx);
    if ((idx >> 4) >= N_WORDS) return 1'b0;
    return line_mem[base + (idx >> 4)][idx & 15];
  endfunction

  function automatic void clear_lines();
    foreach (line_mem[i]) line_mem[i] = '0;
    buf_rot = 0;
    fill_idx = 0;
    flash_lvl = 1'b0;
    frm_open = 1'b0;
  endfunction

  task automatic apply_req(input req_t op, input logic [47:0] t, input logic [7:0] ln,
                           output bit has_flash, output bit flash_bit);
    longint tl, diff, elapsed, lim;
    int     wbase;
    bit     c;
    has_flash = 1'b0;
    flash_bit = 1'b0;
    tl = longint'({16'd0, t});
    wbase = ((buf_rot + 2) % 3) * N_WORDS;
    case (op)
      REQ_TICK: begin
        flash_lvl = ~flash_lvl;
        if (!frm_open) begin
          scroll_ofs += ofs_reg;
          if (scroll_ofs > FULL48) scroll_ofs = FULL48;
          diff = tl - prev_tick;
          if (diff < TICK_GAP) flash_lvl = 1'b0;
          if (scroll_ofs > 2 * diff) scroll_ofs = 0;
          frm_start = tl + scroll_ofs;
          frm_open = 1'b1;
        end
        elapsed = tl - frm_start;
        if (elapsed >= 0) begin
          lim = elapsed / LINE_CYCLES + 1;
          if (lim > N_LINES) lim = N_LINES;
          while (fill_idx < lim) begin
            put_line(wbase, fill_idx, flash_lvl);
            fill_idx++;
          end
        end
        prev_tick = tl;
      end
      REQ_CLEAR: clear_lines();
      REQ_FEND: begin
        if (fill_idx < N_LINES) begin
          c = flash_lvl;
          if (fill_idx != 0) c = get_line(wbase, fill_idx - 1);
          while (fill_idx < N_LINES) begin
            put_line(wbase, fill_idx, c);
            fill_idx++;
          end
        end
        buf_rot = (buf_rot + 1) % 3;
        frm_open = 1'b0;
        fill_idx = 0;
      end
      default: begin
        has_flash = 1'b1;
        flash_bit = get_line(buf_rot * N_WORDS, int'(ln));
      end
    endcase
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic push_req(req_t op, logic [47:0] t, logic [7:0] ln, int known);
    int unsigned gap;
    bit          has_flash, flash_bit;
    if (idle_on && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ln, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_req(op, t, ln, has_flash, flash_bit);
    if (has_flash) line_flash_q.push_back(known >= 0 ? known[0] : flash_bit);
    n_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic push_read();
    push_req(REQ_READ, rnd48(), 8'($urandom_range(0, 255)), -1);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (line_flash_q.size() != 0);
  endtask

  task automatic write_offset(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    ofs_reg = longint'(v);
  endtask

  // well-formed frames with random timing, plus clears, missing frame ends
  // and disordered time
  task automatic run_frames(int unsigned target, inout logic [47:0] cyc_now);
    int unsigned first_sent, k, n_ticks, n_reads;
    first_sent = n_sent;
    while (n_sent - first_sent < target) begin
      if ($urandom_range(0, 99) < 3) push_req(REQ_CLEAR, rnd48(), 8'($urandom()), -1);
      k = $urandom_range(0, 99);
      if (k < 70)      cyc_now += 48'($urandom_range(14336, 45000));
      else if (k < 82) cyc_now += 48'($urandom_range(0, 14335));
      else if (k < 90) cyc_now -= 48'($urandom_range(0, 20000));
      else if (k < 95) cyc_now = rnd48();
      else             cyc_now += 48'($urandom_range(45000, 200000));
      n_ticks = $urandom_range(1, 10);
      repeat (n_ticks) begin
        push_req(REQ_TICK, cyc_now, 8'($urandom()), -1);
        n_reads = $urandom_range(0, 2);
        repeat (n_reads) push_read();
        cyc_now += ($urandom_range(0, 4) == 0) ? 48'd0 : 48'($urandom_range(1, 6000));
      end
      if ($urandom_range(0, 9) != 0) push_req(REQ_FEND, rnd48(), 8'($urandom()), -1);
      n_reads = $urandom_range(1, 5);
      repeat (n_reads) push_read();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: own stall pattern, with one long hold-off on request
  initial begin
    int unsigned rx_mode, run_left, cyc;
    rx_mode = 0;
    run_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          run_left = $urandom_range(20, 200);
        end
        run_left--;
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= cyc[0];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    bit want_bit;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_flash_q.size() == 0) begin
        flag_err($sformatf("unexpected transfer, line_flash=%0b", out_tdata[0]));
      end else begin
        want_bit = line_flash_q.pop_front();
        if (out_tdata[0] !== want_bit)
          flag_err($sformatf("line_flash=%0b, expected %0b", out_tdata[0], want_bit));
      end
    end
  end

  initial begin
    logic [47:0] cyc_now;
    logic [15:0] offsets [4];
    clear_lines();
    frm_start = 0;
    prev_tick = 0;
    scroll_offset_init: scroll_ofs = 0;
    ofs_reg = longint'(SCROLL_STEP_RST);
    offsets = '{16'hFFFF, 16'h0000, 16'($urandom()), 16'd1};
    @(posedge rst_n);
    @(negedge clk);

    foreach (dir_rows[i]) push_req(dir_rows[i].op, dir_rows[i].t, dir_rows[i].ln,
                                   dir_rows[i].known);

    // hold off the result side while reads keep coming
    hold_req = 1'b1;
    repeat (40) push_read();
    wait_drain();
    repeat (40) @(negedge clk);

    cyc_now = 48'($urandom_range(0, 100000));
    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      idle_on = (p != 2);
      run_frames(340, cyc_now);
      wait_drain();
      repeat (40) @(negedge clk);
    end

    write_offset(16'($urandom()));
    idle_on = 1'b1;
    run_frames(40, cyc_now);
    wait_drain();
    repeat (60) @(posedge clk);
    if (line_flash_q.size() != 0) flag_err("expected transfers still pending");

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
